[rtl/ps2_mouse_packet_decoder_top_defines.svh]
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder - assertion macros
// Shared property macros for the checker; clocked on clock, quiet in reset.
// ---------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_DECODER_TOP_DEFINES_SVH
`define PS2_MOUSE_PACKET_DECODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define PS2MD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ps2 mouse decoder: same-cycle property failed");

// Next-cycle implication.
`define PS2MD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ps2 mouse decoder: next-cycle property failed");

`endif

[rtl/ps2md_pkg.sv]
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder - package
// Shared types and constants for the front end, queue and event generator.
// ---------------------------------------------------------------------------
package ps2md_pkg;

   localparam int DATA_PRESENT_BIT    = 5;
   localparam int PACKET_LENGTH       = 3;
   localparam int NUM_BUTTONS         = 3;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [1:0] FIRST_POSITION = 2'd0;
   localparam logic [1:0] X_POSITION     = 2'd1;
   localparam logic [1:0] LAST_POSITION  = 2'(PACKET_LENGTH - 1);
   localparam logic [1:0] BAD_POSITION   = 2'd3;

   localparam logic [1:0] EVENT_MOVE    = 2'd0;
   localparam logic [1:0] EVENT_PRESS   = 2'd1;
   localparam logic [1:0] EVENT_RELEASE = 2'd2;

   // One completed packet as handed from the front end to the generator.
   typedef struct packed {
      logic [7:0]             move_x;
      logic [7:0]             move_y;
      logic [NUM_BUTTONS-1:0] new_buttons;
      logic [NUM_BUTTONS-1:0] changed;
   } packet_cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MOVE,
      BACK_BUTTON
   } back_state_type;

endpackage

[rtl/ps2md_queue.sv]
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder - packet queue
// Small FIFO of decoded packets between the front end and the generator.
// ---------------------------------------------------------------------------
module ps2md_queue #(
   parameter int DEPTH = ps2md_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  ps2md_pkg::packet_cmd_type push_cmd,
   output logic                      full,
   output logic                      pop_valid,
   input  logic                      pop_en,
   output ps2md_pkg::packet_cmd_type pop_cmd
);
   import ps2md_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   packet_cmd_type   entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~full;
   assign do_pop    = pop_en & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/ps2md_front.sv]
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder - front end
// Filters data bytes, assembles three-byte packets and tracks button state.
// ---------------------------------------------------------------------------
module ps2md_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_status_byte,
   input  logic [7:0]                req_data_byte,
   input  logic                      queue_full,
   output logic                      push_valid,
   output ps2md_pkg::packet_cmd_type push_cmd
);
   import ps2md_pkg::*;

   logic [1:0]             pos_ff, pos_in;
   logic [1:0]             pos_now;
   logic [7:0]             byte0_ff, byte1_ff;
   logic [NUM_BUTTONS-1:0] buttons_ff, buttons_in;
   logic                   take;

   assign req_stall = queue_full;
   assign take      = req_valid & ~req_stall & req_status_byte[DATA_PRESENT_BIT];
   assign pos_now   = (pos_ff == BAD_POSITION) ? FIRST_POSITION : pos_ff;

   assign push_valid           = take & (pos_now == LAST_POSITION);
   assign push_cmd.move_x      = byte1_ff;
   assign push_cmd.move_y      = 8'(~req_data_byte + 8'd1);
   assign push_cmd.new_buttons = byte0_ff[NUM_BUTTONS-1:0];
   assign push_cmd.changed     = byte0_ff[NUM_BUTTONS-1:0] ^ buttons_ff;

   always_comb begin
      pos_in     = pos_ff;
      buttons_in = buttons_ff;
      if (take) begin
         pos_in = (pos_now == LAST_POSITION) ? FIRST_POSITION : pos_now + 2'd1;
         if (pos_now == LAST_POSITION) begin
            buttons_in = byte0_ff[NUM_BUTTONS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= FIRST_POSITION;
         buttons_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         buttons_ff <= buttons_in;
      end
   end

   // Packet bytes: hold until overwritten, no reset needed.
   always_ff @(posedge clock) begin
      if (take && pos_now == FIRST_POSITION) begin
         byte0_ff <= req_data_byte;
      end
      if (take && pos_now == X_POSITION) begin
         byte1_ff <= req_data_byte;
      end
   end

endmodule

[rtl/ps2md_back.sv]
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder - event generator
// Expands each packet into a move event and its button events, one per unstalled cycle.
// ---------------------------------------------------------------------------
module ps2md_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_en,
   input  ps2md_pkg::packet_cmd_type pop_cmd,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_event_kind,
   output logic signed [7:0]         rsp_move_x,
   output logic signed [7:0]         rsp_move_y,
   output logic [1:0]                rsp_button_number,
   output logic                      rsp_last_event
);
   import ps2md_pkg::*;

   back_state_type         state_ff, state_in;
   packet_cmd_type         cmd_ff;
   logic [NUM_BUTTONS-1:0] mask_ff, mask_in;
   logic [NUM_BUTTONS-1:0] pick_onehot, remaining;
   logic [1:0]             pick_idx;
   logic                   advance, emit;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             kind_ff, kind_in;
   logic [7:0]             mx_ff, mx_in;
   logic [7:0]             my_ff, my_in;
   logic [1:0]             btn_ff, btn_in;
   logic                   last_ff, last_in;

   assign advance = ~rsp_valid_ff | ~rsp_stall;

   // Lowest pending button first.
   always_comb begin
      if (mask_ff[0]) begin
         pick_idx = 2'd0;
      end else if (mask_ff[1]) begin
         pick_idx = 2'd1;
      end else begin
         pick_idx = 2'd2;
      end
      pick_onehot = NUM_BUTTONS'(1) << pick_idx;
      remaining   = mask_ff & ~pick_onehot;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               state_in = BACK_MOVE;
            end
         end
         BACK_MOVE: begin
            if (advance) begin
               state_in = (mask_ff == '0) ? BACK_IDLE : BACK_BUTTON;
            end
         end
         BACK_BUTTON: begin
            if (advance && remaining == '0) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop_en  = 1'b0;
      emit    = 1'b0;
      mask_in = mask_ff;
      kind_in = EVENT_MOVE;
      mx_in   = 8'd0;
      my_in   = 8'd0;
      btn_in  = 2'd0;
      last_in = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            pop_en  = pop_valid;
            mask_in = pop_cmd.changed;
         end
         BACK_MOVE: begin
            emit    = advance;
            mx_in   = cmd_ff.move_x;
            my_in   = cmd_ff.move_y;
            last_in = (mask_ff == '0);
         end
         BACK_BUTTON: begin
            emit    = advance;
            kind_in = cmd_ff.new_buttons[pick_idx] ? EVENT_PRESS : EVENT_RELEASE;
            btn_in  = pick_idx + 2'd1;
            last_in = (remaining == '0);
            if (advance) begin
               mask_in = remaining;
            end
         end
         default: begin
            pop_en = 1'b0;
         end
      endcase
      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (pop_en) begin
         cmd_ff <= pop_cmd;
      end
      if (emit) begin
         kind_ff <= kind_in;
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         btn_ff  <= btn_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_move_x        = $signed(mx_ff);
   assign rsp_move_y        = $signed(my_ff);
   assign rsp_button_number = btn_ff;
   assign rsp_last_event    = last_ff;

endmodule

[rtl/ps2_mouse_packet_decoder_top.sv]
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder - top level
// Three-byte PS/2 mouse packets in, move and button events out.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: one transaction per controller read (status byte plus data
//    byte). Reads without status bit 5 set are accepted and dropped.
//  - Every third data byte completes a packet; the front end turns it into a
//    packet record (dx, negated dy, button bits, changed buttons)
//    combinationally and pushes it into a small queue.
//  - rsp channel: the generator pops a record and emits a move event, then
//    one press/release event per changed button, lowest button first, one
//    transaction a cycle while rsp is not stalled. The final event of a
//    packet has last_event set.
//  - A packet's record passes the queue, the generator's IDLE and MOVE states
//    and the output register; each record is popped only from IDLE, and req
//    accepts one transaction per cycle while the queue has room.
//  - rsp stall: the output register holds its event; the generator waits,
//    the queue fills, and req stall rises only when the queue is full.
//  - Reset clears position, button state, queue and output valid.
// ---------------------------------------------------------------------------
module ps2_mouse_packet_decoder_top #(
   parameter int QUEUE_DEPTH = ps2md_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_status_byte,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_event_kind,
   output logic signed [7:0] rsp_move_x,
   output logic signed [7:0] rsp_move_y,
   output logic [1:0]        rsp_button_number,
   output logic              rsp_last_event
);
   import ps2md_pkg::*;

   logic           push_valid;
   packet_cmd_type push_cmd;
   logic           queue_full;
   logic           pop_valid;
   logic           pop_en;
   packet_cmd_type pop_cmd;

   // Front end: filter and assemble packets.
   ps2md_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_status_byte (req_status_byte),
      .req_data_byte   (req_data_byte),
      .queue_full      (queue_full),
      .push_valid      (push_valid),
      .push_cmd        (push_cmd)
   );

   // Decouple assembly from event generation.
   ps2md_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_en     (pop_en),
      .pop_cmd    (pop_cmd)
   );

   // Back end: expand packets into events.
   ps2md_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_en            (pop_en),
      .pop_cmd           (pop_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_move_x        (rsp_move_x),
      .rsp_move_y        (rsp_move_y),
      .rsp_button_number (rsp_button_number),
      .rsp_last_event    (rsp_last_event)
   );

endmodule

[rtl/ps2md_checker.sv]
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder - port checker
// Watches the result channel of the top level over time.
// ---------------------------------------------------------------------------
`include "ps2_mouse_packet_decoder_top_defines.svh"

module ps2md_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_event_kind,
   input logic signed [7:0] rsp_move_x,
   input logic signed [7:0] rsp_move_y,
   input logic [1:0]        rsp_button_number,
   input logic              rsp_last_event
);
   import ps2md_pkg::*;

   logic [20:0] rsp_payload;
   logic        move_event;
   logic        button_event;
   logic        no_motion;

   assign rsp_payload  = {rsp_event_kind, rsp_move_x, rsp_move_y, rsp_button_number,
                          rsp_last_event};
   assign move_event   = rsp_valid && (rsp_event_kind == EVENT_MOVE);
   assign button_event = rsp_valid && (rsp_event_kind != EVENT_MOVE);
   assign no_motion    = (rsp_move_x == 8'sd0) && (rsp_move_y == 8'sd0);

   // Stalled event holds.
   `PS2MD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // Move events carry no button number.
   `PS2MD_ASSERT_NOW(a_move_no_button, move_event, rsp_button_number == 2'd0)

   // Button events carry a button and no motion.
   `PS2MD_ASSERT_NOW(a_button_fields, button_event, rsp_button_number != 2'd0 && no_motion)

   // Events of one packet follow back to back.
   `PS2MD_ASSERT_NEXT(a_burst, rsp_valid && !rsp_stall && !rsp_last_event, rsp_valid)

endmodule

bind ps2_mouse_packet_decoder_top ps2md_checker u_checker (.*);
